// ===== rtl/bdtr_pkg.sv =====
// types, constants and helpers shared by the beat division trigger rack
package bdtr_pkg;

	// beats in one bar, span of the bar trigger
	localparam int unsigned BEATS_PER_BAR = 4;

	// trigger positions in the fired mask
	localparam int unsigned TRIG_BAR    = 0;
	localparam int unsigned TRIG_HALF   = 1;
	localparam int unsigned TRIG_BEAT   = 2;
	localparam int unsigned TRIG_DOUBLE = 3;
	localparam int unsigned NUM_TRIG    = 4;

	// field widths
	localparam int unsigned BEAT_W  = 32;
	localparam int unsigned PHASE_W = 16;
	localparam int unsigned BIB_W   = 4;
	localparam int unsigned US_W    = 24;
	localparam int unsigned HITS_W  = 32;

	// product of the phase offset beyond one half and the beat period
	localparam int unsigned PROD_W = (PHASE_W - 1) + US_W;

	typedef logic [HITS_W-1:0] hits_t;

	// one tick item from the beat clock
	typedef struct packed {
		logic [BEAT_W-1:0]   beat_index;
		logic [PHASE_W-1:0]  beat_phase;
		logic [BIB_W-1:0]    beat_in_bar;
		logic [US_W-1:0]     time_since_beat_us;
		logic [US_W-1:0]     beat_period_us;
		logic [NUM_TRIG-1:0] armed_mask;
	} tick_t;

	// one result item
	typedef struct packed {
		logic [NUM_TRIG-1:0] fired_mask;
		logic [US_W-1:0]     since_hit_bar_us;
		logic [US_W-1:0]     since_hit_half_us;
		logic [US_W-1:0]     since_hit_beat_us;
		logic [US_W-1:0]     since_hit_double_us;
		hits_t               hits_bar;
		hits_t               hits_half;
		hits_t               hits_beat;
		hits_t               hits_double;
	} result_t;

	// true when beat_in_bar is a whole multiple of the bar length
	function automatic logic is_bar_start(input logic [BIB_W-1:0] bib);
		logic hit;
		hit = 1'b0;
		for (int unsigned k = 0; k < (1 << BIB_W); k++) begin
			if (k * BEATS_PER_BAR < (1 << BIB_W)) begin
				hit = hit | (bib == BIB_W'(k * BEATS_PER_BAR));
			end
		end
		return hit;
	endfunction

endpackage

// ===== rtl/beat_division_trigger_rack.sv =====
// beat division trigger rack: input register, trigger logic, result register
//
// Takes one tick item per cycle while tick_ready is high and gives one result
// item per tick. Each tick is held in an input stage, where the bar, half, beat
// and double triggers are evaluated together by one pass of logic (a 15 x 24
// bit multiply for the mid-beat time of the double trigger); the trigger state
// and hit counts update as the item moves into the result register. The first
// tick after reset seats the rack on the beat grid and fires only armed
// triggers. Both sides may stall freely; a stalled full result register does
// not stop a tick from being taken into an empty input stage, but holds the
// next one out while the input stage is full.
module beat_division_trigger_rack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick_valid,
	output logic                    tick_ready,
	input  bdtr_pkg::tick_t         tick,
	output logic                    result_valid,
	input  logic                    result_ready,
	output bdtr_pkg::result_t       result
);

	// input stage
	logic               valid_s1;
	bdtr_pkg::tick_t    tick_s1;
	logic               advance;

	// trigger state
	logic                                 seated_q;
	logic [bdtr_pkg::BEAT_W-1:0]          last_beat_q;
	logic                                 offbeat_done_q;
	bdtr_pkg::hits_t                      hit_cnt_q [bdtr_pkg::NUM_TRIG];

	// trigger logic
	logic                                 new_beat;
	logic                                 mid_hit;
	logic [bdtr_pkg::NUM_TRIG-1:0]        grid_hit;
	logic [bdtr_pkg::NUM_TRIG-1:0]        fired;
	logic [bdtr_pkg::PROD_W-1:0]          mid_prod;
	logic [bdtr_pkg::US_W-1:0]            mid_time;
	logic [bdtr_pkg::US_W-1:0]            since [bdtr_pkg::NUM_TRIG];
	bdtr_pkg::hits_t                      hit_next [bdtr_pkg::NUM_TRIG];

	// result register
	logic               valid_q;
	bdtr_pkg::result_t  result_q;

	// handshake: the input stage moves on whenever the result slot frees
	assign advance    = valid_s1 && (!valid_q || result_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
	end

	// grid and mid-beat decisions
	assign new_beat = seated_q && (tick_s1.beat_index != last_beat_q);
	assign mid_hit  = seated_q && !new_beat && !offbeat_done_q && tick_s1.beat_phase[15];

	// mid-beat time: (phase - one half) * period, Q0.16 scaled back
	assign mid_prod = bdtr_pkg::PROD_W'(tick_s1.beat_phase[14:0])
		* bdtr_pkg::PROD_W'(tick_s1.beat_period_us);
	assign mid_time = bdtr_pkg::US_W'(mid_prod[bdtr_pkg::PROD_W-1:16]);

	always_comb begin
		grid_hit = '0;
		if (new_beat) begin
			grid_hit[bdtr_pkg::TRIG_BAR]    = bdtr_pkg::is_bar_start(tick_s1.beat_in_bar);
			grid_hit[bdtr_pkg::TRIG_HALF]   = !tick_s1.beat_in_bar[0];
			grid_hit[bdtr_pkg::TRIG_BEAT]   = 1'b1;
			grid_hit[bdtr_pkg::TRIG_DOUBLE] = 1'b1;
		end
		fired = grid_hit | tick_s1.armed_mask;
		fired[bdtr_pkg::TRIG_DOUBLE] = fired[bdtr_pkg::TRIG_DOUBLE] | mid_hit;
	end

	// per-trigger time since hit and next hit count
	always_comb begin
		for (int unsigned i = 0; i < bdtr_pkg::NUM_TRIG; i++) begin
			if (grid_hit[i]) begin
				since[i] = tick_s1.time_since_beat_us;
			end else if (i == bdtr_pkg::TRIG_DOUBLE && mid_hit) begin
				since[i] = mid_time;
			end else begin
				since[i] = '0;
			end
			hit_next[i] = hit_cnt_q[i] + bdtr_pkg::HITS_W'(fired[i]);
		end
	end

	// trigger state update as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seated_q       <= 1'b0;
			last_beat_q    <= '0;
			offbeat_done_q <= 1'b0;
			for (int unsigned i = 0; i < bdtr_pkg::NUM_TRIG; i++) begin
				hit_cnt_q[i] <= '0;
			end
		end else if (advance) begin
			if (!seated_q) begin
				seated_q       <= 1'b1;
				last_beat_q    <= tick_s1.beat_index;
				offbeat_done_q <= tick_s1.beat_phase[15];
			end else if (new_beat) begin
				last_beat_q    <= tick_s1.beat_index;
				offbeat_done_q <= 1'b0;
			end else if (mid_hit) begin
				offbeat_done_q <= 1'b1;
			end
			for (int unsigned i = 0; i < bdtr_pkg::NUM_TRIG; i++) begin
				hit_cnt_q[i] <= hit_next[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.fired_mask          <= fired;
			result_q.since_hit_bar_us    <= since[bdtr_pkg::TRIG_BAR];
			result_q.since_hit_half_us   <= since[bdtr_pkg::TRIG_HALF];
			result_q.since_hit_beat_us   <= since[bdtr_pkg::TRIG_BEAT];
			result_q.since_hit_double_us <= since[bdtr_pkg::TRIG_DOUBLE];
			result_q.hits_bar            <= hit_next[bdtr_pkg::TRIG_BAR];
			result_q.hits_half           <= hit_next[bdtr_pkg::TRIG_HALF];
			result_q.hits_beat           <= hit_next[bdtr_pkg::TRIG_BEAT];
			result_q.hits_double         <= hit_next[bdtr_pkg::TRIG_DOUBLE];
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// counts cannot move before the rack is seated
	a_counts_idle_unseated: assert property (@(posedge clk) disable iff (!arst_n)
		!seated_q |-> (hit_cnt_q[bdtr_pkg::TRIG_BAR] == '0)
			&& (hit_cnt_q[bdtr_pkg::TRIG_DOUBLE] == '0))
		else $error("hit count moved before seating");

	// a result just loaded carries the live hit counts
	a_result_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid && (result.hits_bar == hit_cnt_q[bdtr_pkg::TRIG_BAR])
			&& (result.hits_double == hit_cnt_q[bdtr_pkg::TRIG_DOUBLE]))
		else $error("result hit counts out of step with state");

	// a stalled input stage keeps its item
	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(tick_s1))
		else $error("input stage lost a stalled item");

	// the mid-beat hit is taken once per beat
	a_mid_once: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mid_hit |=> offbeat_done_q && !mid_hit)
		else $error("mid-beat hit not recorded");

	// a grid hit always fires beat and double together
	a_grid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		advance && new_beat |=> result.fired_mask[bdtr_pkg::TRIG_BEAT]
			&& result.fired_mask[bdtr_pkg::TRIG_DOUBLE])
		else $error("new beat without beat and double hits");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the beat division trigger rack
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdtr_pkg::*;

	localparam logic [PHASE_W-1:0] PHASE_HALF = 16'h8000;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS  = 425;

	// hit tracker: keeps its own trigger state and the queue of expected results
	class trigger_rack_tracker;
		bit                seated;
		logic [BEAT_W-1:0] last_beat;
		bit                offbeat_done;
		hits_t             hit_count [NUM_TRIG];
		result_t           expected_results [$];
		int unsigned       mismatches;

		function new();
			seated = 1'b0;
			last_beat = '0;
			offbeat_done = 1'b0;
			foreach (hit_count[i]) hit_count[i] = '0;
			mismatches = 0;
		endfunction

		// beats between grid hits of each trigger
		function int unsigned span_of(int unsigned trig);
			case (trig)
				TRIG_BAR:  return BEATS_PER_BAR;
				TRIG_HALF: return 2;
				default:   return 1;
			endcase
		endfunction

		// work out the result of one accepted tick and queue it
		function void take_tick(tick_t t);
			logic [NUM_TRIG-1:0] fired;
			logic [US_W-1:0]     since [NUM_TRIG];
			logic [PHASE_W-1:0]  offset;
			logic [63:0]         product;
			int unsigned         span;
			result_t             r;
			fired = '0;
			foreach (since[i]) since[i] = '0;
			if (!seated) begin
				// first tick only seats the rack on the grid
				seated = 1'b1;
				last_beat = t.beat_index;
				offbeat_done = (t.beat_phase >= PHASE_HALF);
			end else if (t.beat_index != last_beat) begin
				// new beat: grid hits by span
				last_beat = t.beat_index;
				offbeat_done = 1'b0;
				for (int unsigned i = 0; i < NUM_TRIG; i++) begin
					span = span_of(i);
					if (span <= 1 || (t.beat_in_bar % span) == 0) begin
						fired[i] = 1'b1;
						since[i] = t.time_since_beat_us;
					end
				end
			end else if (!offbeat_done && t.beat_phase >= PHASE_HALF) begin
				// mid-beat hit of the double trigger
				offset = t.beat_phase - PHASE_HALF;
				product = 64'(offset) * 64'(t.beat_period_us);
				offbeat_done = 1'b1;
				fired[TRIG_DOUBLE] = 1'b1;
				since[TRIG_DOUBLE] = US_W'(product >> 16);
			end
			// armed triggers fire with zero time, then counts move on
			for (int unsigned i = 0; i < NUM_TRIG; i++) begin
				if (t.armed_mask[i] && !fired[i]) begin
					fired[i] = 1'b1;
					since[i] = '0;
				end
				if (fired[i]) hit_count[i] = hit_count[i] + 1'b1;
			end
			r.fired_mask          = fired;
			r.since_hit_bar_us    = since[TRIG_BAR];
			r.since_hit_half_us   = since[TRIG_HALF];
			r.since_hit_beat_us   = since[TRIG_BEAT];
			r.since_hit_double_us = since[TRIG_DOUBLE];
			r.hits_bar            = hit_count[TRIG_BAR];
			r.hits_half           = hit_count[TRIG_HALF];
			r.hits_beat           = hit_count[TRIG_BEAT];
			r.hits_double         = hit_count[TRIG_DOUBLE];
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got, inout bit bad);
			if (got !== want) begin
				bad = 1'b1;
				if (mismatches < 10)
					$display("%0t: %s expected %h, got %h", $realtime, name, want, got);
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			bit      bad;
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result item with none expected: %h", $realtime, got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			bad = 1'b0;
			compare("fired_mask", 32'(want.fired_mask), 32'(got.fired_mask), bad);
			compare("since_hit_bar_us", 32'(want.since_hit_bar_us),
				32'(got.since_hit_bar_us), bad);
			compare("since_hit_half_us", 32'(want.since_hit_half_us),
				32'(got.since_hit_half_us), bad);
			compare("since_hit_beat_us", 32'(want.since_hit_beat_us),
				32'(got.since_hit_beat_us), bad);
			compare("since_hit_double_us", 32'(want.since_hit_double_us),
				32'(got.since_hit_double_us), bad);
			compare("hits_bar", want.hits_bar, got.hits_bar, bad);
			compare("hits_half", want.hits_half, got.hits_half, bad);
			compare("hits_beat", want.hits_beat, got.hits_beat, bad);
			compare("hits_double", want.hits_double, got.hits_double, bad);
			if (bad) mismatches++;
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    tick_valid = 1'b0;
	logic    tick_ready;
	tick_t   tick = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned sent = 0;
	int unsigned quiet_cycles = 0;

	trigger_rack_tracker board = new();

	beat_division_trigger_rack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// note accepted items on both sides, drive result stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && tick_ready) board.take_tick(tick);
			if (result_valid && result_ready) board.check_result(result);
			if ((tick_valid && tick_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog on cycles with no item moving
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	function automatic tick_t clock_tick(logic [BEAT_W-1:0] beat, logic [PHASE_W-1:0] phase,
			logic [BIB_W-1:0] bib, logic [US_W-1:0] since_beat, logic [US_W-1:0] period,
			logic [NUM_TRIG-1:0] armed);
		tick_t t;
		t.beat_index         = beat;
		t.beat_phase         = phase;
		t.beat_in_bar        = bib;
		t.time_since_beat_us = since_beat;
		t.beat_period_us     = period;
		t.armed_mask         = armed;
		return t;
	endfunction

	// offer one tick item, with random idle gaps before it
	task automatic send_tick(input tick_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		tick_valid <= 1'b1;
		tick <= item;
		do @(posedge clk); while (!tick_ready);
		sent++;
	endtask

	function automatic logic [NUM_TRIG-1:0] random_armed();
		return ($urandom_range(0, 7) == 0) ? NUM_TRIG'($urandom_range(1, 15)) : '0;
	endfunction

	// a stretch of well-formed clock readings over a few beats
	task automatic play_beat_run(input int unsigned beats);
		logic [BEAT_W-1:0] beat;
		logic [US_W-1:0]   period;
		logic [63:0]       elapsed;
		int unsigned       per_bar;
		int unsigned       bar_pos;
		int unsigned       ticks;
		int unsigned       phase;
		beat = $urandom();
		per_bar = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : BEATS_PER_BAR;
		bar_pos = $urandom_range(0, per_bar - 1);
		case ($urandom_range(0, 9))
			0:       period = '0;
			1, 2:    period = US_W'($urandom());
			default: period = US_W'($urandom_range(200000, 2000000));
		endcase
		for (int unsigned b = 0; b < beats; b++) begin
			ticks = $urandom_range(1, 6);
			phase = $urandom_range(0, 16'h3000);
			for (int unsigned k = 0; k < ticks; k++) begin
				elapsed = (64'(phase) * 64'(period)) >> 16;
				send_tick(clock_tick(beat, PHASE_W'(phase), BIB_W'(bar_pos),
					US_W'(elapsed), period, random_armed()));
				phase = phase + $urandom_range(0, 16'h6000);
				if (phase > 16'hFFFF) phase = 16'hFFFF;
			end
			// mostly the next beat, now and then a skip
			beat = beat + (($urandom_range(0, 15) == 0) ? $urandom_range(2, 9) : 1);
			bar_pos = (bar_pos + 1) % per_bar;
		end
	endtask

	initial begin
		tick_t       noise;
		logic [127:0] noise_bits;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: seating, grid hits, mid-beat hits, armed triggers
		send_tick(clock_tick(32'hFFFF_FFFF, 16'hFFFF, 4'hF, 24'hFF_FFFF, 24'hFF_FFFF, 4'hF));
		send_tick(clock_tick(32'hFFFF_FFFF, 16'hFFFF, 4'h0, 24'h00_0000, 24'hFF_FFFF, 4'h0));
		send_tick(clock_tick(32'h0000_0000, 16'h0000, 4'h0, 24'hFF_FFFF, 24'd500000, 4'h0));
		send_tick(clock_tick(32'h0000_0000, 16'h7FFF, 4'h0, 24'd249992, 24'd500000, 4'h0));
		send_tick(clock_tick(32'h0000_0000, 16'h8000, 4'h0, 24'd250000, 24'hFF_FFFF, 4'h0));
		send_tick(clock_tick(32'h0000_0000, 16'hFFFF, 4'h0, 24'd499999, 24'd500000, 4'h0));
		send_tick(clock_tick(32'h0000_0001, 16'hFFFF, 4'h1, 24'd100, 24'd500000, 4'h0));
		send_tick(clock_tick(32'h0000_0001, 16'hFFFF, 4'h1, 24'd200, 24'hFF_FFFF, 4'h0));
		send_tick(clock_tick(32'h0000_0002, 16'h0100, 4'h2, 24'd0, 24'd480000, 4'h0));
		send_tick(clock_tick(32'h0000_0002, 16'hC000, 4'h2, 24'd360000, 24'd0, 4'h7));
		send_tick(clock_tick(32'h0000_0003, 16'h0000, 4'hF, 24'd0, 24'd480000, 4'h3));
		send_tick(clock_tick(32'h0000_0004, 16'h0000, 4'h8, 24'd77, 24'd480000, 4'h0));
		send_tick(clock_tick(32'h0000_0005, 16'h0000, 4'hC, 24'd12, 24'd480000, 4'hF));
		send_tick(clock_tick(32'h8000_0000, 16'h4000, 4'hE, 24'h12_3456, 24'd480000, 4'h0));
		send_tick(clock_tick(32'h8000_0000, 16'h8001, 4'hE, 24'h23_4567, 24'h01_0000, 4'h0));
		send_tick(clock_tick(32'h8000_0000, 16'h9000, 4'hE, 24'd5, 24'd480000, 4'h1));
		send_tick(clock_tick(32'h8000_0000, 16'h9000, 4'hE, 24'd5, 24'd480000, 4'h2));
		send_tick(clock_tick(32'h8000_0000, 16'h9000, 4'hE, 24'd5, 24'd480000, 4'h4));
		send_tick(clock_tick(32'h8000_0000, 16'h9000, 4'hE, 24'd5, 24'd480000, 4'h8));
		send_tick(clock_tick(32'h8000_0001, 16'h8000, 4'h4, 24'd0, 24'h00_0001, 4'h0));
		send_tick(clock_tick(32'h8000_0001, 16'h8000, 4'h4, 24'd0, 24'h00_0001, 4'h0));

		// random: beat runs with some noise, through the idling phases
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			while (sent < (p + 1) * PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					noise_bits = {$urandom(), $urandom(), $urandom(), $urandom()};
					noise = tick_t'(noise_bits[$bits(tick_t)-1:0]);
					send_tick(noise);
				end else begin
					play_beat_run($urandom_range(1, 8));
				end
			end
		end
		tick_valid <= 1'b0;

		// drain, then a few more cycles to catch stray results
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
